/* sv/dpq_pkg.sv */
// shared types for the double-ended priority queue
// command codes and the control word broadcast to every cell; no dependencies
package dpq_pkg;

  localparam int ValW  = 32;
  localparam int CntOW = 9;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_POP_MAX = 2'd1,
    CMD_POP_MIN = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  // broadcast to the cell row for one transaction
  typedef struct packed {
    logic                   ins;      // insert that fits
    logic                   pop_max;  // remove largest, store not empty
    logic                   pop_min;  // remove smallest, store not empty
    logic                   clr;      // clear all
    logic signed [ValW-1:0] value;
  } ctl_t;

endpackage

/* sv/dpq_cell.sv */
// one slot of the sorted cell row
// depends on dpq_pkg; trades values with its left and right neighbors
module dpq_cell
  import dpq_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 9
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctl_t                   ctl,
  input  logic [CW-1:0]          count,
  input  logic signed [ValW-1:0] left_val,
  input  logic                   left_gt,
  input  logic                   left_top,
  input  logic signed [ValW-1:0] right_val,
  input  logic                   right_top,
  output logic signed [ValW-1:0] val,
  output logic                   gt,
  output logic                   top,
  output logic [ValW-1:0]        masked
);

  logic signed [ValW-1:0] val_r, val_nxt;
  logic                   top_r, top_nxt;
  logic                   occ, at_count;

  assign occ      = CW'(IDX) < count;
  assign at_count = count == CW'(IDX);
  assign gt       = occ && (val_r > ctl.value);

  // sorted insert: shift right above the slot, drop value into the slot; remove smallest shifts values left
  always_comb begin
    val_nxt = val_r;
    if (ctl.ins) begin
      if (left_gt) begin
        val_nxt = left_val;
      end else if (gt || at_count) begin
        val_nxt = ctl.value;
      end
    end else if (ctl.pop_min) begin
      val_nxt = right_val;
    end
  end

  // top marker follows the last occupied slot
  always_comb begin
    top_nxt = top_r;
    if (ctl.clr) begin
      top_nxt = 1'b0;
    end else if (ctl.ins) begin
      top_nxt = left_top;
    end else if (ctl.pop_max || ctl.pop_min) begin
      top_nxt = right_top;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= 1'b0;
    end else begin
      top_r <= top_nxt;
    end
  end

  assign val    = val_r;
  assign top    = top_r;
  assign masked = top_r ? val_r : '0;

endmodule

/* sv/double_ended_priority_queue.sv */
// double-ended priority queue top level
// depends on dpq_pkg and dpq_cell
//
// Keeps up to CAPACITY signed 32-bit values sorted ascending in a row of
// cells, smallest in cell 0. Each input transaction is one command (insert,
// remove largest, remove smallest, clear) and produces exactly one result
// transaction with the empty flag, largest and smallest values (zero when
// empty), the count and a dropped flag for an insert into a full store.
// In the accept cycle every cell compares the broadcast value and moves
// one step toward its neighbor; once the output register is free, the
// cell carrying the top marker is selected into it. The row is tracked
// by a fill count, so no clearing pass runs after reset and the first
// command can be sent right away. A finished result may wait in the
// output register while the next command is taken.
module double_ended_priority_queue
  import dpq_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_cmd,
  input  logic signed [ValW-1:0] in_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_is_empty,
  output logic signed [ValW-1:0] out_largest,
  output logic signed [ValW-1:0] out_smallest,
  output logic [CntOW-1:0]       out_count,
  output logic                   out_dropped
);

  localparam int CW = $clog2(CAPACITY + 1);

  // fill count and transaction control
  logic [CW-1:0] count_r, count_nxt;
  logic          pend_r, drop_r;
  logic          in_acc, full, nonempty, ld;
  ctl_t          ctl;

  // cell row wiring
  logic signed [ValW-1:0] val_w    [CAPACITY];
  logic [ValW-1:0]        masked_w [CAPACITY];
  logic [CAPACITY-1:0]    gt_w, top_w;
  logic [ValW-1:0]        largest_sel;

  // output register
  logic                   out_valid_r;
  logic                   is_empty_r, dropped_r;
  logic signed [ValW-1:0] largest_r, smallest_r;
  logic [CntOW-1:0]       count_out_r;

  assign in_stall = pend_r;
  assign in_acc   = in_valid && !pend_r;
  assign full     = count_r == CW'(CAPACITY);
  assign nonempty = count_r != '0;

  // decode the command into the broadcast control word
  always_comb begin
    ctl       = '0;
    ctl.value = in_value;
    count_nxt = count_r;
    if (in_acc) begin
      case (cmd_t'(in_cmd))
        CMD_INSERT: begin
          if (!full) begin
            ctl.ins   = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_POP_MAX: begin
          if (nonempty) begin
            ctl.pop_max = 1'b1;
            count_nxt   = count_r - 1'b1;
          end
        end
        CMD_POP_MIN: begin
          if (nonempty) begin
            ctl.pop_min = 1'b1;
            count_nxt   = count_r - 1'b1;
          end
        end
        CMD_CLEAR: begin
          ctl.clr   = 1'b1;
          count_nxt = '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_acc) begin
        pend_r <= 1'b1;
      end else if (ld) begin
        pend_r <= 1'b0;
      end
    end
  end

  // refused insert flag rides along with the pending transaction
  always_ff @(posedge clk) begin
    if (in_acc) begin
      drop_r <= (cmd_t'(in_cmd) == CMD_INSERT) && full;
    end
  end

  // the cell row; cell 0 holds the smallest value
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ValW-1:0] lv, rv;
    logic                   lg, lt, rt;
    if (i == 0) begin : g_first
      assign lv = '0;
      assign lg = 1'b0;
      assign lt = !nonempty;  // first insert into an empty row lands here
    end else begin : g_mid_l
      assign lv = val_w[i-1];
      assign lg = gt_w[i-1];
      assign lt = top_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rv = val_w[i];
      assign rt = 1'b0;
    end else begin : g_mid_r
      assign rv = val_w[i+1];
      assign rt = top_w[i+1];
    end
    dpq_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .count     (count_r),
      .left_val  (lv),
      .left_gt   (lg),
      .left_top  (lt),
      .right_val (rv),
      .right_top (rt),
      .val       (val_w[i]),
      .gt        (gt_w[i]),
      .top       (top_w[i]),
      .masked    (masked_w[i])
    );
  end

  // at most one cell carries the top marker, so an or of masked values selects it
  always_comb begin
    largest_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      largest_sel = largest_sel | masked_w[i];
    end
  end

  // load the result once the row has settled and the output side is free
  assign ld = pend_r && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      is_empty_r  <= !nonempty;
      largest_r   <= largest_sel;
      smallest_r  <= nonempty ? val_w[0] : '0;
      count_out_r <= CntOW'(count_r);
      dropped_r   <= drop_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_is_empty = is_empty_r;
  assign out_largest  = largest_r;
  assign out_smallest = smallest_r;
  assign out_count    = count_out_r;
  assign out_dropped  = dropped_r;

  // top marker sits on exactly one cell when the row is occupied
  a_top_onehot : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(top_w))
    else $error("more than one top marker");

  a_top_count : assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) == (top_w != '0))
    else $error("top marker disagrees with fill count");

  a_count_cap : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_accept_pend : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> pend_r)
    else $error("accepted transaction not pending");

  a_drop_full : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && dropped_r) |-> (count_out_r == CntOW'(CAPACITY)))
    else $error("dropped insert reported while not full");

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench for the double-ended priority queue
// depends on dpq_pkg and double_ended_priority_queue; keeps its own sorted copy of the store
module tb_top
  import dpq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Capacity      = 256;
  localparam int RandomItems   = 1875;
  localparam int WatchdogLimit = 500;
  localparam int DrainCycles   = 10;

  // one result transaction as the block reports it
  typedef struct {
    logic                   is_empty;
    logic signed [ValW-1:0] largest;
    logic signed [ValW-1:0] smallest;
    logic [CntOW-1:0]       count;
    logic                   dropped;
  } dpq_result_t;

  // one row of the directed table; want is only used when typed is set
  typedef struct {
    cmd_t                   cmd;
    logic signed [ValW-1:0] value;
    bit                     typed;
    dpq_result_t            want;
  } plan_row_t;

  // command mix of one random phase
  typedef enum {
    LOAD_FILL,
    LOAD_DRAIN,
    LOAD_MIXED
  } load_mode_t;

  logic                   clk          = 1'b0;
  logic                   rst_n        = 1'b0;
  logic                   in_valid     = 1'b0;
  logic                   in_stall;
  logic [1:0]             in_cmd       = CMD_CLEAR;
  logic signed [ValW-1:0] in_value     = '0;
  logic                   out_valid;
  logic                   out_stall    = 1'b0;
  logic                   out_is_empty;
  logic signed [ValW-1:0] out_largest;
  logic signed [ValW-1:0] out_smallest;
  logic [CntOW-1:0]       out_count;
  logic                   out_dropped;

  // sorted copy of the store, smallest first
  logic signed [ValW-1:0] store_vals[$];
  // expected results in command order
  dpq_result_t            pending_results[$];
  dpq_result_t            got_want;
  plan_row_t              plan[$];

  int  mismatches  = 0;
  int  idle_cycles = 0;
  int  recv_hold   = 0;
  // when set, neither side inserts gaps or stalls
  bit  quiet       = 1'b0;

  always #5 clk = ~clk;

  double_ended_priority_queue #(
    .CAPACITY(Capacity)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cmd      (in_cmd),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_is_empty(out_is_empty),
    .out_largest (out_largest),
    .out_smallest(out_smallest),
    .out_count   (out_count),
    .out_dropped (out_dropped)
  );

  // apply one command to the local store and return what the block should report
  function automatic dpq_result_t apply_to_store(cmd_t c, logic signed [ValW-1:0] v);
    dpq_result_t r;
    int          pos;
    r.dropped = 1'b0;
    case (c)
      CMD_INSERT: begin
        if (store_vals.size() >= Capacity) begin
          // full store refuses the value and leaves everything as it was
          r.dropped = 1'b1;
        end else begin
          // duplicates land after their equals, order among them is invisible
          pos = store_vals.size();
          while (pos > 0 && store_vals[pos-1] > v) pos--;
          store_vals.insert(pos, v);
        end
      end
      CMD_POP_MAX: begin
        if (store_vals.size() > 0) void'(store_vals.pop_back());
      end
      CMD_POP_MIN: begin
        if (store_vals.size() > 0) void'(store_vals.pop_front());
      end
      default: begin
        store_vals.delete();
      end
    endcase
    r.is_empty = (store_vals.size() == 0);
    // empty store reports zero for both ends
    r.largest  = r.is_empty ? '0 : store_vals[store_vals.size()-1];
    r.smallest = r.is_empty ? '0 : store_vals[0];
    r.count    = CntOW'(store_vals.size());
    return r;
  endfunction

  function automatic plan_row_t typed_row(cmd_t c, logic signed [ValW-1:0] v, logic e,
                                          logic signed [ValW-1:0] hi,
                                          logic signed [ValW-1:0] lo, int n);
    plan_row_t r;
    r.cmd           = c;
    r.value         = v;
    r.typed         = 1'b1;
    r.want.is_empty = e;
    r.want.largest  = hi;
    r.want.smallest = lo;
    r.want.count    = CntOW'(n);
    r.want.dropped  = 1'b0;
    return r;
  endfunction

  function automatic plan_row_t predicted_row(cmd_t c, logic signed [ValW-1:0] v);
    plan_row_t r;
    r.cmd   = c;
    r.value = v;
    r.typed = 1'b0;
    return r;
  endfunction

  // mostly wide random values, with a slice of extremes and a narrow band for duplicates
  function automatic logic signed [ValW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2, 3:    return int'($urandom_range(0, 15)) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t pick_cmd(load_mode_t mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      // net growth of about 0.8 per command, enough to hit the full store
      LOAD_FILL: begin
        if (r < 90)      return CMD_INSERT;
        else if (r < 95) return CMD_POP_MAX;
        else             return CMD_POP_MIN;
      end
      // shrinks toward empty so removes on an empty store show up
      LOAD_DRAIN: begin
        if (r < 25)      return CMD_INSERT;
        else if (r < 60) return CMD_POP_MAX;
        else if (r < 97) return CMD_POP_MIN;
        else             return CMD_CLEAR;
      end
      default: begin
        if (r < 48)      return CMD_INSERT;
        else if (r < 73) return CMD_POP_MAX;
        else if (r < 98) return CMD_POP_MIN;
        else             return CMD_CLEAR;
      end
    endcase
  endfunction

  // present one command transaction, hold it until taken, then record what it should give
  task automatic send_cmd(input cmd_t c, input logic signed [ValW-1:0] v,
                          input bit typed, input dpq_result_t typed_want);
    int          gap;
    dpq_result_t model_out;
    gap = quiet ? 0 : $urandom_range(0, 5);
    // valid only drops when a gap follows, so back-to-back commands keep it high
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= c;
    in_value <= v;
    do @(posedge clk); while (in_stall !== 1'b0);
    model_out = apply_to_store(c, v);
    pending_results.push_back(typed ? typed_want : model_out);
  endtask

  // result side: check every accepted result, then draw the stall for the next one
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $error("result transaction with nothing pending: count %0d", out_count);
        end else begin
          got_want = pending_results.pop_front();
          if (out_is_empty !== got_want.is_empty) begin
            mismatches++;
            $error("is_empty: expected %0b, got %0b", got_want.is_empty, out_is_empty);
          end
          if (out_largest !== got_want.largest) begin
            mismatches++;
            $error("largest: expected %0d, got %0d", got_want.largest, out_largest);
          end
          if (out_smallest !== got_want.smallest) begin
            mismatches++;
            $error("smallest: expected %0d, got %0d", got_want.smallest, out_smallest);
          end
          if (out_count !== got_want.count) begin
            mismatches++;
            $error("count: expected %0d, got %0d", got_want.count, out_count);
          end
          if (out_dropped !== got_want.dropped) begin
            mismatches++;
            $error("dropped: expected %0b, got %0b", got_want.dropped, out_dropped);
          end
        end
        recv_hold = quiet ? 0 : $urandom_range(0, 5);
        out_stall <= (recv_hold != 0);
      end else if (out_valid && out_stall) begin
        if (recv_hold > 0) recv_hold--;
        out_stall <= (recv_hold != 0);
      end
    end
  end

  // watchdog: too long without a transaction on either side means the block hung
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    load_mode_t mode;
    int         sent;
    int         phase_len;
    cmd_t       c;
    dpq_result_t no_want;

    // directed table: empty-store removes and clear, both extremes, duplicates,
    // ignored value on non-insert commands, clear of a loaded store
    plan.push_back(typed_row(CMD_POP_MAX, 32'sh12345678, 1'b1, 0, 0, 0));
    plan.push_back(typed_row(CMD_POP_MIN, 32'sh80000000, 1'b1, 0, 0, 0));
    plan.push_back(typed_row(CMD_CLEAR, 32'sh7fffffff, 1'b1, 0, 0, 0));
    plan.push_back(typed_row(CMD_INSERT, 32'sh7fffffff, 1'b0,
                             32'sh7fffffff, 32'sh7fffffff, 1));
    plan.push_back(typed_row(CMD_INSERT, 32'sh80000000, 1'b0,
                             32'sh7fffffff, 32'sh80000000, 2));
    plan.push_back(predicted_row(CMD_INSERT, 0));
    plan.push_back(predicted_row(CMD_INSERT, 0));
    plan.push_back(predicted_row(CMD_INSERT, -1));
    plan.push_back(predicted_row(CMD_INSERT, 1));
    plan.push_back(predicted_row(CMD_POP_MAX, 32'shffffffff));
    plan.push_back(predicted_row(CMD_POP_MIN, 32'sh55555555));
    plan.push_back(predicted_row(CMD_POP_MIN, 32'shaaaaaaaa));
    plan.push_back(predicted_row(CMD_POP_MIN, 0));
    plan.push_back(predicted_row(CMD_POP_MAX, 0));
    plan.push_back(predicted_row(CMD_POP_MAX, 0));
    plan.push_back(typed_row(CMD_POP_MIN, 32'sh0000ffff, 1'b1, 0, 0, 0));
    plan.push_back(typed_row(CMD_INSERT, 32'shffffffff, 1'b0,
                             32'shffffffff, 32'shffffffff, 1));
    plan.push_back(typed_row(CMD_CLEAR, 32'shffff0000, 1'b1, 0, 0, 0));
    plan.push_back(predicted_row(CMD_INSERT, 7));
    plan.push_back(predicted_row(CMD_INSERT, 7));
    plan.push_back(predicted_row(CMD_INSERT, -7));
    plan.push_back(predicted_row(CMD_POP_MAX, 32'shffffffff));
    plan.push_back(typed_row(CMD_CLEAR, 0, 1'b1, 0, 0, 0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) send_cmd(plan[i].cmd, plan[i].value, plan[i].typed, plan[i].want);

    // random part: phases of different command mix, the first one fills the store
    // past capacity so refused inserts are exercised early
    sent = 0;
    mode = LOAD_FILL;
    while (sent < RandomItems) begin
      phase_len = (mode == LOAD_FILL) ? $urandom_range(320, 420) : $urandom_range(120, 400);
      // about one phase in four runs without any gaps or stalls
      quiet = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < phase_len && sent < RandomItems; k++) begin
        c = pick_cmd(mode);
        // non-insert commands carry random noise in the value field
        send_cmd(c, (c == CMD_INSERT) ? pick_value() : $urandom, 1'b0, no_want);
        sent++;
      end
      mode = load_mode_t'($urandom_range(0, 2));
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // let any stray result transaction show up before closing
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* double_ended_priority_queue.f */
sv/dpq_pkg.sv
sv/dpq_cell.sv
sv/double_ended_priority_queue.sv
tb/sv/tb_top.sv
